>>> design/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared constants, types and the command class table for the standard
// frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned NUM_ARGS  = 5;
   localparam int unsigned CNT_W     = 3;   // holds an argument count of 0..5
   localparam int unsigned POS_W     = 4;   // holds a frame position of 0..8
   localparam int unsigned ARG_SEL_W = 3;

   typedef logic [BYTE_W-1:0]                byte_type;
   typedef logic [NUM_ARGS-1:0][BYTE_W-1:0]  args_type;
   typedef logic [CNT_W-1:0]                 count_type;
   typedef logic [POS_W-1:0]                 pos_type;
   typedef logic [ARG_SEL_W-1:0]             arg_sel_type;

   localparam byte_type FRAME_START      = 8'hF1;
   localparam byte_type FRAME_STOP       = 8'hF2;
   localparam byte_type OP_EMPTY         = 8'h00;
   localparam byte_type OP_SET_USER_INFO = 8'h2B;

   // Number of argument bytes that follow a command, by command class.
   function automatic count_type arg_count(input byte_type op);
      count_type n;
      begin
         case (op)
            8'h01, 8'h04, 8'h05, 8'h10, 8'h13, 8'h29,
            8'h2D, 8'h30, 8'h36, 8'h42, 8'h43, 8'h44: n = 3'd1;
            8'h23, 8'h24, 8'h33, 8'h35, 8'h40, 8'h41: n = 3'd2;
            8'h11, 8'h12, 8'h20, 8'h21, 8'h22, 8'h25,
            8'h28, 8'h2C, 8'h34:                      n = 3'd3;
            OP_SET_USER_INFO:                         n = 3'd5;
            default:                                  n = 3'd0;
         endcase
         return n;
      end
   endfunction

endpackage

>>> design/cfb_req_if.sv
// ----------------------------------------------------------------------------
// cfb_req_if
// Command channel: one command byte and five argument bytes per item.
// ----------------------------------------------------------------------------
interface cfb_req_if;
   logic              valid;
   logic              ready;
   cfb_pkg::byte_type opcode;
   cfb_pkg::byte_type arg0;
   cfb_pkg::byte_type arg1;
   cfb_pkg::byte_type arg2;
   cfb_pkg::byte_type arg3;
   cfb_pkg::byte_type arg4;

   modport source (output valid, output opcode, output arg0, output arg1,
                   output arg2, output arg3, output arg4, input ready);
   modport sink   (input valid, input opcode, input arg0, input arg1,
                   input arg2, input arg3, input arg4, output ready);
endinterface

>>> design/cfb_rsp_if.sv
// ----------------------------------------------------------------------------
// cfb_rsp_if
// Frame channel: one frame byte per item, flagged on the closing byte.
// ----------------------------------------------------------------------------
interface cfb_rsp_if;
   logic              valid;
   logic              ready;
   cfb_pkg::byte_type frame_byte;
   logic              last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

>>> design/csafe_command_frame_builder_core.sv
// ----------------------------------------------------------------------------
// csafe_command_frame_builder_core
// Builds an unstuffed standard frame (start flag, command, arguments,
// XOR checksum, stop flag) and sends it one byte per item.
// ----------------------------------------------------------------------------
// A command's start flag reaches rsp via the frame and result registers.
// Throughput: one byte per cycle while rsp is ready, set by the one-byte
// result channel; a frame has 3 to 9 bytes (2 + arguments + checksum + 1).
// The next command is taken on the cycle its predecessor's stop flag leaves
// the frame register, so frames run back to back without gaps.
// Reset clears the valid flags and the byte position; no payload is reset.
module csafe_command_frame_builder_core (
   input  logic      clock,
   input  logic      reset,
   cfb_req_if.sink   req_if,
   cfb_rsp_if.source rsp_if
);

   // Frame register: the command being sent.
   logic                 item_valid_ff, item_valid_in;
   cfb_pkg::byte_type    op_ff, op_in;
   cfb_pkg::args_type    args_ff, args_in;
   cfb_pkg::byte_type    chk_ff, chk_in;
   cfb_pkg::pos_type     stop_pos_ff, stop_pos_in;
   cfb_pkg::pos_type     pos_ff, pos_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   cfb_pkg::byte_type    rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 load_item;
   logic                 advance;
   logic                 at_stop;
   logic                 has_chk;
   cfb_pkg::count_type   req_cnt;
   cfb_pkg::arg_sel_type arg_sel;
   cfb_pkg::pos_type     arg_pos;
   cfb_pkg::byte_type    sel_arg;
   cfb_pkg::byte_type    cur_byte;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign at_stop   = (pos_ff == stop_pos_ff);
   assign req_if.ready = !item_valid_ff || (advance && at_stop);
   assign load_item = req_if.valid && req_if.ready;

   // Load side: argument count, stop position and checksum.
   always_comb begin
      args_in = {req_if.arg4, req_if.arg3, req_if.arg2, req_if.arg1, req_if.arg0};
      op_in   = req_if.opcode;
      req_cnt = cfb_pkg::arg_count(req_if.opcode);
      chk_in  = req_if.opcode;
      for (int i = 0; i < cfb_pkg::NUM_ARGS; i++) begin
         if (cfb_pkg::count_type'(i) < req_cnt) begin
            chk_in = chk_in ^ args_in[i];
         end
      end
      stop_pos_in = cfb_pkg::pos_type'(2) + {1'b0, req_cnt}
                  + {3'b000, (req_if.opcode != cfb_pkg::OP_EMPTY)};
   end

   // Byte select for the current frame position.
   always_comb begin
      has_chk = (op_ff != cfb_pkg::OP_EMPTY);
      arg_pos = pos_ff - cfb_pkg::pos_type'(2);
      arg_sel = arg_pos[cfb_pkg::ARG_SEL_W-1:0];
      unique case (arg_sel)
         3'd0:    sel_arg = args_ff[0];
         3'd1:    sel_arg = args_ff[1];
         3'd2:    sel_arg = args_ff[2];
         3'd3:    sel_arg = args_ff[3];
         3'd4:    sel_arg = args_ff[4];
         default: sel_arg = args_ff[0];
      endcase
      priority if (pos_ff == cfb_pkg::pos_type'(0)) begin
         cur_byte = cfb_pkg::FRAME_START;
      end else if (pos_ff == cfb_pkg::pos_type'(1)) begin
         cur_byte = op_ff;
      end else if (at_stop) begin
         cur_byte = cfb_pkg::FRAME_STOP;
      end else if (has_chk && (pos_ff == stop_pos_ff - cfb_pkg::pos_type'(1))) begin
         cur_byte = chk_ff;
      end else begin
         cur_byte = sel_arg;
      end
   end

   // Next-state logic for the frame and result registers.
   always_comb begin
      item_valid_in = item_valid_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = at_stop;
         pos_in       = pos_ff + cfb_pkg::pos_type'(1);
         if (at_stop) begin
            item_valid_in = 1'b0;
         end
      end
      if (load_item) begin
         item_valid_in = 1'b1;
         pos_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_item) begin
         op_ff       <= op_in;
         args_ff     <= args_in;
         chk_ff      <= chk_in;
         stop_pos_ff <= stop_pos_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.frame_byte = rsp_byte_ff;
   assign rsp_if.last_byte  = rsp_last_ff;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Sends command items to the frame builder under random sender gaps and
// receiver stalls, predicts each frame byte by byte and checks every byte
// that leaves the block against the oldest one still awaited.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned HOLD_CYCLES   = 300;

   // Command classes by number of argument bytes; set-user-info takes five and everything else has none.
   localparam logic [11:0][7:0] ONE_ARG_CMDS = {
      8'h01, 8'h04, 8'h05, 8'h10, 8'h13, 8'h29,
      8'h2D, 8'h30, 8'h36, 8'h42, 8'h43, 8'h44};
   localparam logic [5:0][7:0]  TWO_ARG_CMDS = {
      8'h23, 8'h24, 8'h33, 8'h35, 8'h40, 8'h41};
   localparam logic [8:0][7:0]  THREE_ARG_CMDS = {
      8'h11, 8'h12, 8'h20, 8'h21, 8'h22, 8'h25, 8'h28, 8'h2C, 8'h34};
   localparam int unsigned NUM_KNOWN_CMDS = 28;

   typedef struct packed {
      cfb_pkg::byte_type frame_byte;
      logic              last_byte;
   } framed_byte_type;

   class frame_scoreboard;

      framed_byte_type awaited_bytes[$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int unsigned payload_len(cfb_pkg::byte_type op);
         if (op == cfb_pkg::OP_SET_USER_INFO)
            return 5;
         for (int i = 0; i < $size(ONE_ARG_CMDS); i++)
            if (op == ONE_ARG_CMDS[i]) return 1;
         for (int i = 0; i < $size(TWO_ARG_CMDS); i++)
            if (op == TWO_ARG_CMDS[i]) return 2;
         for (int i = 0; i < $size(THREE_ARG_CMDS); i++)
            if (op == THREE_ARG_CMDS[i]) return 3;
         return 0;
      endfunction

      // Walks all commands that take arguments, indexed 0 to NUM_KNOWN_CMDS-1.
      function cfb_pkg::byte_type known_command(int unsigned idx);
         if (idx < 12)
            return ONE_ARG_CMDS[idx];
         idx = idx - 12;
         if (idx < 6)
            return TWO_ARG_CMDS[idx];
         idx = idx - 6;
         if (idx < 9)
            return THREE_ARG_CMDS[idx];
         return cfb_pkg::OP_SET_USER_INFO;
      endfunction

      function void await_byte(cfb_pkg::byte_type value, logic last);
         framed_byte_type entry;
         entry.frame_byte = value;
         entry.last_byte  = last;
         awaited_bytes    = {awaited_bytes, entry};
      endfunction

      // Expands one accepted command into the bytes of its frame.
      function void note_command(cfb_pkg::byte_type op, cfb_pkg::args_type args);
         cfb_pkg::byte_type checksum;
         int unsigned       n;
         n        = payload_len(op);
         checksum = op;
         await_byte(cfb_pkg::FRAME_START, 1'b0);
         await_byte(op, 1'b0);
         for (int i = 0; i < n; i++) begin
            await_byte(args[i], 1'b0);
            checksum = checksum ^ args[i];
         end
         if (op != cfb_pkg::OP_EMPTY)
            await_byte(checksum, 1'b0);
         await_byte(cfb_pkg::FRAME_STOP, 1'b1);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_byte(cfb_pkg::byte_type value, logic last);
         framed_byte_type entry;
         if (awaited_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected frame byte %h last %b", value, last));
         end else begin
            entry = awaited_bytes.pop_front();
            if (value !== entry.frame_byte)
               report_mismatch($sformatf("frame_byte %h, expected %h",
                                         value, entry.frame_byte));
            if (last !== entry.last_byte)
               report_mismatch($sformatf("last_byte %b, expected %b on byte %h",
                                         last, entry.last_byte, entry.frame_byte));
         end
      endtask

      function int unsigned pending();
         return awaited_bytes.size();
      endfunction

      task final_check();
         if (awaited_bytes.size() != 0)
            report_mismatch($sformatf("%0d frame bytes never arrived",
                                      awaited_bytes.size()));
      endtask

   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfb_req_if req_ch ();
   cfb_rsp_if rsp_ch ();

   csafe_command_frame_builder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   frame_scoreboard sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        rsp_hold      = 1'b0;
   int unsigned cycle_count   = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_command(req_ch.opcode, {req_ch.arg4, req_ch.arg3, req_ch.arg2,
                                         req_ch.arg1, req_ch.arg0});
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_byte(rsp_ch.frame_byte, rsp_ch.last_byte);
   end

   task send_command(cfb_pkg::byte_type op, cfb_pkg::args_type args);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.arg0   <= args[0];
      req_ch.arg1   <= args[1];
      req_ch.arg2   <= args[2];
      req_ch.arg3   <= args[3];
      req_ch.arg4   <= args[4];
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   function cfb_pkg::byte_type random_arg();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         2:       return cfb_pkg::FRAME_START;
         3:       return cfb_pkg::FRAME_STOP;
         default: return cfb_pkg::byte_type'($urandom);
      endcase
   endfunction

   // Mostly commands with arguments, some empty and some unknown opcodes.
   task send_random_commands(int unsigned count);
      cfb_pkg::byte_type op;
      cfb_pkg::args_type args;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0:       op = cfb_pkg::OP_EMPTY;
            1, 2:    op = cfb_pkg::byte_type'($urandom);
            default: op = sb.known_command($urandom_range(NUM_KNOWN_CMDS - 1));
         endcase
         for (int j = 0; j < cfb_pkg::NUM_ARGS; j++)
            args[j] = random_arg();
         send_command(op, args);
      end
   endtask

   task hold_off_receiver(int unsigned cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   task send_directed_commands();
      // Empty command ignores all arguments and carries no checksum.
      send_command(cfb_pkg::OP_EMPTY, '1);
      // Unknown opcodes, including the flag values, act as dataless commands.
      send_command('1, {8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h69});
      send_command(cfb_pkg::FRAME_START, '1);
      send_command(cfb_pkg::FRAME_STOP, '0);
      send_command(ONE_ARG_CMDS[11], {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
      send_command(ONE_ARG_CMDS[0], {8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});
      // Flag bytes inside the payload are sent unescaped.
      send_command(TWO_ARG_CMDS[5], {8'h00, 8'h00, 8'h00, cfb_pkg::FRAME_STOP,
                                     cfb_pkg::FRAME_START});
      send_command(TWO_ARG_CMDS[0], {8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
      send_command(THREE_ARG_CMDS[8], '0);
      send_command(THREE_ARG_CMDS[0], '1);
      send_command(cfb_pkg::OP_SET_USER_INFO, '0);
      send_command(cfb_pkg::OP_SET_USER_INFO, '1);
      send_command(cfb_pkg::OP_SET_USER_INFO,
                   {cfb_pkg::FRAME_START, cfb_pkg::FRAME_STOP, cfb_pkg::FRAME_START,
                    cfb_pkg::FRAME_STOP, cfb_pkg::FRAME_START});
      // Checksums that land on the flag values.
      send_command(ONE_ARG_CMDS[0],
                   {8'h00, 8'h00, 8'h00, 8'h00,
                    cfb_pkg::FRAME_STOP ^ ONE_ARG_CMDS[0]});
      send_command(THREE_ARG_CMDS[1],
                   {8'h00, 8'h00, 8'h0F, 8'hF0,
                    cfb_pkg::FRAME_START ^ 8'hFF ^ THREE_ARG_CMDS[1]});
   endtask

   initial begin
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= '0;
      req_ch.arg0   <= '0;
      req_ch.arg1   <= '0;
      req_ch.arg2   <= '0;
      req_ch.arg3   <= '0;
      req_ch.arg4   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 79;
      send_directed_commands();
      send_random_commands(80);

      send_idle_pct = 79;
      recv_idle_pct = 25;
      send_random_commands(80);

      // No idling; a long receiver hold-off makes the block back up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         hold_off_receiver(HOLD_CYCLES);
         send_random_commands(95);
      join
      req_ch.valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.final_check();

      if (sb.mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
